[sv/rsrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrd_pkg
// Shared types, command codes and helpers of the run-length sprite row
// decoder.
// ----------------------------------------------------------------------------
package rsrd_pkg;

  localparam int unsigned ColW      = 11;
  localparam int unsigned CountW    = 12;
  localparam logic [ColW-1:0] MaxWidth  = 11'd1024;
  localparam logic [ColW-1:0] ColSat    = 11'd2047;
  localparam logic [9:0]      RunXSat   = 10'd1023;

  localparam logic [7:0] OpSkipCount = 8'h03;
  localparam logic [7:0] OpNone      = 8'h00;
  localparam logic [7:0] OpOne       = 8'h01;
  localparam logic [3:0] NibEndRow   = 4'hF;
  localparam logic [3:0] NibFill     = 4'h7;
  localparam logic [3:0] NibPList    = 4'h6;
  localparam logic [3:0] NibPFill    = 4'hA;
  localparam logic [3:0] NibGList    = 4'h2;
  localparam logic [1:0] LowList     = 2'b00;
  localparam logic [1:0] LowSkip     = 2'b01;
  localparam logic [7:0] EndRowByte  = {4'h0, NibEndRow};

  typedef enum logic [1:0] {
    KIND_ROW_START = 2'd0,
    KIND_ROW_SKIP  = 2'd1,
    KIND_STREAM    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_UNKNOWN = 2'd1,
    ERR_WIDTH   = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_COUNT   = 3'd1,
    PH_GLOW    = 3'd2,
    PH_LIST    = 3'd3,
    PH_FILLVAL = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    CL_LIST  = 3'd0,
    CL_PLIST = 3'd1,
    CL_FILL  = 3'd2,
    CL_PFILL = 3'd3,
    CL_SKIP  = 3'd4
  } class_e;

  localparam logic [0:0] RegFrameWidth = 1'b0;
  localparam logic [0:0] RegPlayerRow  = 1'b1;

  // Phase that takes the data once the count of a command is known.
  function automatic phase_e data_phase(input class_e cls, input logic [CountW-1:0] cnt);
    phase_e ph;
    if (cls == CL_FILL || cls == CL_PFILL) begin
      ph = PH_FILLVAL;
    end else if (cnt != '0) begin
      ph = PH_LIST;
    end else begin
      ph = PH_OPCODE;
    end
    return ph;
  endfunction

  // Player colour: add 16 times (row plus one), modulo 256.
  function automatic logic [7:0] player_add(input logic [7:0] b, input logic [3:0] row);
    logic [3:0] rp1;
    rp1 = row + 4'd1;
    return b + {rp1, 4'b0000};
  endfunction

endpackage

[sv/rle_sprite_row_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_sprite_row_decoder
// Decodes a run-length sprite row command stream into pixel runs.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the output side does not stall
// and gives at most one run per word. A word passes an input register, is
// decoded by one level of logic against the row state, and its run lands in an
// output register. Stalls on the output side hold the pipeline; the input
// register keeps taking words while the output register drains. Configuration
// writes take effect on the next decoded word.
module rle_sprite_row_decoder
  import rsrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from low: left_margin[9:0], stream_byte[17:10], zero padding.
  input  logic [23:0] s_axis_tdata,
  // Bits from low: kind[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from low: run_x[9:0], run_length[17:10], pixel_value[25:18],
  // uses_player_color[26], zero padding.
  output logic [31:0] m_axis_tdata,
  // Bits from low: error_code[1:0].
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i
);

  logic [ColW-1:0]   frame_width_q;
  logic [3:0]        player_row_q;

  logic              in_valid_q;
  logic [1:0]        in_kind_q;
  logic [9:0]        in_margin_q;
  logic [7:0]        in_byte_q;

  phase_e            phase_q, phase_d;
  class_e            cls_q, cls_d;
  logic [CountW-1:0] left_q, left_d;
  logic [ColW-1:0]   column_q, column_d;
  logic              player_q, player_d;
  logic              resync_q, resync_d;

  logic              out_valid_q;
  logic [9:0]        out_x_q;
  logic [7:0]        out_len_q;
  logic [7:0]        out_val_q;
  logic              out_end_q;
  logic              out_player_q;
  err_e              out_err_q;

  logic              proc;
  logic              res_valid;
  logic [7:0]        res_len;
  logic [7:0]        res_val;
  logic              res_end;
  err_e              res_err;
  logic              run_req;
  logic [7:0]        run_len;
  logic [7:0]        run_val;
  logic [ColW-1:0]   limit;
  logic [ColW:0]     run_end;
  logic [3:0]        lo_nib;
  logic [3:0]        hi_nib;
  logic [7:0]        pl_byte;

  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;

  assign lo_nib  = in_byte_q[3:0];
  assign hi_nib  = in_byte_q[7:4];
  assign pl_byte = player_add(in_byte_q, player_row_q);
  assign limit   = (frame_width_q < MaxWidth) ? frame_width_q : MaxWidth;

  always_comb begin
    phase_d  = phase_q;
    cls_d    = cls_q;
    left_d   = left_q;
    column_d = column_q;
    player_d = player_q;
    resync_d = resync_q;
    run_req  = 1'b0;
    run_len  = '0;
    run_val  = '0;
    res_valid = 1'b0;
    res_len  = '0;
    res_val  = '0;
    res_end  = 1'b0;
    res_err  = ERR_OK;

    if (in_kind_q == KIND_ROW_START) begin
      column_d = {1'b0, in_margin_q};
      phase_d  = PH_OPCODE;
      cls_d    = CL_LIST;
      left_d   = '0;
      resync_d = 1'b0;
    end else if (in_kind_q == KIND_STREAM) begin
      if (resync_q) begin
        if (in_byte_q == EndRowByte) begin
          resync_d  = 1'b0;
          phase_d   = PH_OPCODE;
          res_valid = 1'b1;
          res_end   = 1'b1;
        end
      end else begin
        unique case (phase_q)
          PH_COUNT: begin
            if (cls_q == CL_SKIP) begin
              phase_d = PH_OPCODE;
              run_req = 1'b1;
              run_len = in_byte_q;
            end else begin
              left_d  = {4'h0, in_byte_q};
              phase_d = data_phase(cls_q, {4'h0, in_byte_q});
            end
          end
          PH_GLOW: begin
            left_d  = left_q | {4'h0, in_byte_q};
            phase_d = data_phase(cls_q, left_q | {4'h0, in_byte_q});
          end
          PH_LIST: begin
            left_d  = left_q - 12'd1;
            if (left_q == {{(CountW-1){1'b0}}, 1'b1}) begin
              phase_d = PH_OPCODE;
            end
            run_req = 1'b1;
            run_len = 8'd1;
            run_val = (cls_q == CL_PLIST) ? pl_byte : in_byte_q;
          end
          PH_FILLVAL: begin
            phase_d = PH_OPCODE;
            run_req = 1'b1;
            run_len = left_q[7:0];
            run_val = (cls_q == CL_PFILL) ? pl_byte : in_byte_q;
          end
          default: begin
            phase_d = PH_OPCODE;
            if (in_byte_q == OpSkipCount) begin
              cls_d   = CL_SKIP;
              phase_d = PH_COUNT;
            end else if (in_byte_q[1:0] == LowList && in_byte_q != OpNone) begin
              cls_d   = CL_LIST;
              left_d  = {6'd0, in_byte_q[7:2]};
              phase_d = PH_LIST;
            end else if (in_byte_q[1:0] == LowSkip && in_byte_q != OpOne) begin
              run_req = 1'b1;
              run_len = {2'b00, in_byte_q[7:2]};
            end else if (lo_nib == NibEndRow) begin
              res_valid = 1'b1;
              res_end   = 1'b1;
            end else if (lo_nib == NibFill || lo_nib == NibPList || lo_nib == NibPFill) begin
              if (lo_nib == NibFill) begin
                cls_d = CL_FILL;
              end else if (lo_nib == NibPList) begin
                cls_d = CL_PLIST;
              end else begin
                cls_d = CL_PFILL;
              end
              if (lo_nib != NibFill) begin
                player_d = 1'b1;
              end
              if (hi_nib == 4'h0) begin
                phase_d = PH_COUNT;
              end else begin
                left_d  = {8'h00, hi_nib};
                phase_d = data_phase(cls_d, {8'h00, hi_nib});
              end
            end else if (lo_nib == NibGList) begin
              cls_d   = CL_LIST;
              left_d  = {hi_nib, 8'h00};
              phase_d = PH_GLOW;
            end else begin
              resync_d  = 1'b1;
              res_valid = 1'b1;
              res_err   = ERR_UNKNOWN;
            end
          end
        endcase
      end
    end

    run_end = {1'b0, column_q} + {4'b0000, run_len};
    if (run_req && run_len != 8'd0) begin
      res_valid = 1'b1;
      if (run_end > {1'b0, limit}) begin
        res_err = ERR_WIDTH;
      end else begin
        res_len = run_len;
        res_val = run_val;
      end
      column_d = run_end[ColW] ? ColSat : run_end[ColW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= MaxWidth;
      player_row_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegFrameWidth) begin
        frame_width_q <= cfg_wdata_i;
      end else begin
        player_row_q  <= cfg_wdata_i[3:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_OPCODE;
      cls_q       <= CL_LIST;
      left_q      <= '0;
      column_q    <= '0;
      player_q    <= 1'b0;
      resync_q    <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (proc) begin
        phase_q  <= phase_d;
        cls_q    <= cls_d;
        left_q   <= left_d;
        column_q <= column_d;
        player_q <= player_d;
        resync_q <= resync_d;
        out_valid_q <= res_valid;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind_q   <= s_axis_tuser;
      in_margin_q <= s_axis_tdata[9:0];
      in_byte_q   <= s_axis_tdata[17:10];
    end
    if (proc && res_valid) begin
      out_x_q      <= column_q[ColW-1] ? RunXSat : column_q[9:0];
      out_len_q    <= res_len;
      out_val_q    <= res_val;
      out_end_q    <= res_end;
      out_player_q <= player_q;
      out_err_q    <= res_err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_player_q, out_val_q, out_len_q, out_x_q};
  assign m_axis_tuser  = out_err_q;
  assign m_axis_tlast  = out_end_q;

  a_end_is_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[17:10] == 8'd0 && m_axis_tuser == ERR_OK)
    else $error("row end word carries pixels or an error");

  a_err_is_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ERR_OK |-> m_axis_tdata[25:10] == 16'd0 && !m_axis_tlast)
    else $error("error word carries a run");

  a_resync_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    resync_q |-> phase_q == PH_OPCODE)
    else $error("resync outside the opcode phase");

  a_player_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    player_q |=> player_q)
    else $error("player colour flag cleared");

endmodule
